@@ rtl/core/awr_pkg.sv @@
package awr_pkg;

    localparam int BUCKET_COUNT     = 60;
    localparam int BUCKET_LENGTH_MS = 60000;
    localparam int PERMILLE_SCALE   = 1000;
    localparam int HOUR_MS          = 3600000;
    localparam int FIGURE_MAX       = 65535;

    // Per mille of an hour reduces to a plain division by this figure.
    localparam int PERMILLE_DIV = HOUR_MS / PERMILLE_SCALE;

    // Smallest sum whose per mille figure is past the top figure.
    localparam int SAT_LIMIT = (FIGURE_MAX + 1) * PERMILLE_DIV;

    localparam int SLOT_W      = $clog2(BUCKET_COUNT);
    localparam int SUM_W       = SLOT_W + 32;

    // Each fixed divisor is replaced by its reciprocal rounded up at a scale of
    // 2^(32 + ceil(log2 divisor)), which gives the exact quotient of any 32-bit dividend.
    localparam int SHIFT_BUCKET   = 32 + $clog2(BUCKET_LENGTH_MS);
    localparam int SHIFT_RING     = 32 + $clog2(BUCKET_COUNT);
    localparam int SHIFT_PERMILLE = 32 + $clog2(PERMILLE_DIV);

    localparam logic [32:0] RECIP_BUCKET = 33'(((64'd1 << SHIFT_BUCKET)
        + 64'(BUCKET_LENGTH_MS) - 64'd1) / 64'(BUCKET_LENGTH_MS));
    localparam logic [32:0] RECIP_RING = 33'(((64'd1 << SHIFT_RING)
        + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT));
    localparam logic [32:0] RECIP_PERMILLE = 33'(((64'd1 << SHIFT_PERMILLE)
        + 64'(PERMILLE_DIV) - 64'd1) / 64'(PERMILLE_DIV));

    localparam logic [1:0] DIV_BUCKET   = 2'd0;
    localparam logic [1:0] DIV_RING     = 2'd1;
    localparam logic [1:0] DIV_PERMILLE = 2'd2;

    localparam logic OP_FRAME  = 1'b0;
    localparam logic OP_REPORT = 1'b1;
    localparam logic DIR_RX    = 1'b0;
    localparam logic DIR_TX    = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] time_ms;
        logic        direction;
        logic [15:0] duration_ms;
    } cmd_t;

    typedef struct packed {
        logic [15:0] rx_permille;
        logic [15:0] tx_permille;
    } rpt_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [31:0] rx_total;
        logic [31:0] tx_total;
    } bucket_t;

endpackage

@@ rtl/core/awr_div.sv @@
module awr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  sel,
    input  logic [31:0] dividend,
    output logic        done,
    output logic [31:0] quotient
);
    import awr_pkg::*;

    logic        done_reg;
    logic [1:0]  sel_reg;
    logic [64:0] prod_reg;
    logic [32:0] recip;
    logic [64:0] scaled;

    // Division by a fixed divisor: one multiply by the scaled reciprocal, then a shift.
    always_comb
    begin
        unique case (sel)
            DIV_BUCKET: recip = RECIP_BUCKET;
            DIV_RING:   recip = RECIP_RING;
            default:    recip = RECIP_PERMILLE;
        endcase
    end

    always_comb
    begin
        unique case (sel_reg)
            DIV_BUCKET: scaled = prod_reg >> SHIFT_BUCKET;
            DIV_RING:   scaled = prod_reg >> SHIFT_RING;
            default:    scaled = prod_reg >> SHIFT_PERMILLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sel_reg  <= sel;
            prod_reg <= 65'(dividend) * 65'(recip);
        end
    end

    assign done     = done_reg;
    assign quotient = scaled[31:0];

endmodule

@@ rtl/core/airtime_window_rollup.sv @@
// Rolling one-hour airtime counter built on a ring of BUCKET_COUNT buckets of
// BUCKET_LENGTH_MS each, with one receive and one transmit total per bucket.
// A frame beat adds its duration to the bucket of its start time and gives no
// result; a report beat gives one result with the live receive and transmit
// airtime as per mille of an hour, saturated at 65535. The block takes one
// beat at a time and holds cmd_stall high until that beat is done. Every
// division is by a fixed divisor and goes through one shared reciprocal
// multiplier, and the bucket store has a single read port, so a frame keeps
// cmd_stall high through two divisions, a bucket read and a write, and a
// report through one division, a walk over all BUCKET_COUNT buckets and two
// more divisions, longer while an earlier result still waits on rpt_stall.
// The store is clear right after reset; no clearing pass is needed.
module airtime_window_rollup (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  awr_pkg::cmd_t cmd,
    output logic          rpt_valid,
    input  logic          rpt_stall,
    output awr_pkg::rpt_t rpt
);
    import awr_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LD_T     = 4'd1;
    localparam logic [3:0] S_DIV_T    = 4'd2;
    localparam logic [3:0] S_LD_SLOT  = 4'd3;
    localparam logic [3:0] S_DIV_SLOT = 4'd4;
    localparam logic [3:0] S_RD       = 4'd5;
    localparam logic [3:0] S_WR       = 4'd6;
    localparam logic [3:0] S_WALK     = 4'd7;
    localparam logic [3:0] S_LAST     = 4'd8;
    localparam logic [3:0] S_LD_RX    = 4'd9;
    localparam logic [3:0] S_DIV_RX   = 4'd10;
    localparam logic [3:0] S_LD_TX    = 4'd11;
    localparam logic [3:0] S_DIV_TX   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;

    cmd_t              item_reg;
    logic [31:0]       epoch_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              acc_en_reg;
    logic [SUM_W-1:0]  rx_acc_reg;
    logic [SUM_W-1:0]  tx_acc_reg;
    logic [15:0]       rx_fig_reg;
    logic [15:0]       tx_fig_reg;
    logic              rpt_valid_reg;
    rpt_t              rpt_reg;

    bucket_t           mem [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0] valid_reg;
    bucket_t           rd_data_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;
    bucket_t           rd_entry;
    bucket_t           upd_entry;

    logic              div_start;
    logic [1:0]        div_sel;
    logic [31:0]       div_dividend;
    logic              div_done;
    logic [31:0]       div_quotient;

    logic              accept;
    logic              rpt_load;
    logic              live;
    logic [31:0]       age;
    logic [15:0]       figure;
    logic [31:0]       rx_clip;
    logic [31:0]       tx_clip;
    logic [31:0]       ring_rem;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = state_reg != S_IDLE;
    assign rpt_load  = (state_reg == S_DONE) && (!rpt_valid_reg || !rpt_stall);

    awr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sel      (div_sel),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // A sum at or past the saturation point is clipped so that its figure lands just
    // past the top and saturates.
    assign rx_clip = (rx_acc_reg >= SUM_W'(SAT_LIMIT)) ? 32'(SAT_LIMIT) : rx_acc_reg[31:0];
    assign tx_clip = (tx_acc_reg >= SUM_W'(SAT_LIMIT)) ? 32'(SAT_LIMIT) : tx_acc_reg[31:0];

    always_comb
    begin
        div_start    = 1'b0;
        div_sel      = DIV_BUCKET;
        div_dividend = '0;
        unique case (state_reg)
            S_LD_T:
            begin
                div_start    = 1'b1;
                div_sel      = DIV_BUCKET;
                div_dividend = item_reg.time_ms;
            end
            S_LD_SLOT:
            begin
                div_start    = 1'b1;
                div_sel      = DIV_RING;
                div_dividend = epoch_reg;
            end
            S_LD_RX:
            begin
                div_start    = 1'b1;
                div_sel      = DIV_PERMILLE;
                div_dividend = rx_clip;
            end
            S_LD_TX:
            begin
                div_start    = 1'b1;
                div_sel      = DIV_PERMILLE;
                div_dividend = tx_clip;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign figure = (div_quotient > 32'(FIGURE_MAX)) ? 16'(FIGURE_MAX)
                                                     : div_quotient[15:0];

    assign ring_rem = epoch_reg - div_quotient * 32'(BUCKET_COUNT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (accept) state_next = S_LD_T;
            S_LD_T:     state_next = S_DIV_T;
            S_DIV_T:
            begin
                if (div_done)
                    state_next = (item_reg.operation == OP_FRAME) ? S_LD_SLOT : S_WALK;
            end
            S_LD_SLOT:  state_next = S_DIV_SLOT;
            S_DIV_SLOT: if (div_done) state_next = S_RD;
            S_RD:       state_next = S_WR;
            S_WR:       state_next = S_IDLE;
            S_WALK:     if (idx_reg == SLOT_W'(BUCKET_COUNT - 1)) state_next = S_LAST;
            S_LAST:     state_next = S_LD_RX;
            S_LD_RX:    state_next = S_DIV_RX;
            S_DIV_RX:   if (div_done) state_next = S_LD_TX;
            S_LD_TX:    state_next = S_DIV_TX;
            S_DIV_TX:   if (div_done) state_next = S_DONE;
            S_DONE:     if (rpt_load) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            acc_en_reg    <= 1'b0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_en_reg <= state_reg == S_WALK;
            if (accept)
                idx_reg <= '0;
            else if (state_reg == S_WALK)
                idx_reg <= idx_reg + 1'b1;
            if (rpt_load)
                rpt_valid_reg <= 1'b1;
            else if (!rpt_stall)
                rpt_valid_reg <= 1'b0;
        end
    end

    // Bucket store: one read and one write port, read data registered.
    assign rd_addr = (state_reg == S_WALK) ? idx_reg : slot_reg;
    assign mem_we  = state_reg == S_WR;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[slot_reg] <= upd_entry;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                valid_reg[slot_reg] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // A slot never written since reset holds epoch zero with empty totals.
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        upd_entry = rd_entry;
        if (rd_entry.epoch != epoch_reg)
        begin
            upd_entry       = '0;
            upd_entry.epoch = epoch_reg;
        end
        if (item_reg.direction == DIR_TX)
            upd_entry.tx_total = upd_entry.tx_total + 32'(item_reg.duration_ms);
        else
            upd_entry.rx_total = upd_entry.rx_total + 32'(item_reg.duration_ms);
    end

    // The wrapping age puts future buckets out of the window as well.
    assign age  = epoch_reg - rd_entry.epoch;
    assign live = ((rd_entry.rx_total != '0) || (rd_entry.tx_total != '0))
                  && (age < 32'(BUCKET_COUNT));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= cmd;
            rx_acc_reg <= '0;
            tx_acc_reg <= '0;
        end
        else if (acc_en_reg && live)
        begin
            rx_acc_reg <= rx_acc_reg + SUM_W'(rd_entry.rx_total);
            tx_acc_reg <= tx_acc_reg + SUM_W'(rd_entry.tx_total);
        end
        if ((state_reg == S_DIV_T) && div_done)
            epoch_reg <= div_quotient;
        if ((state_reg == S_DIV_SLOT) && div_done)
            slot_reg <= ring_rem[SLOT_W-1:0];
        if ((state_reg == S_DIV_RX) && div_done)
            rx_fig_reg <= figure;
        if ((state_reg == S_DIV_TX) && div_done)
            tx_fig_reg <= figure;
        if (rpt_load)
        begin
            rpt_reg.rx_permille <= rx_fig_reg;
            rpt_reg.tx_permille <= tx_fig_reg;
        end
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

endmodule

@@ rtl/core/awr_checker.sv @@
module awr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input awr_pkg::cmd_t cmd,
    input logic          rpt_valid,
    input logic          rpt_stall,
    input awr_pkg::rpt_t rpt
);
    import awr_pkg::*;

    // Every accepted beat keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("beat accepted while the block did not go busy");

    // A frame never produces a result.
    a_frame_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.operation == OP_FRAME) |=> !$rose(rpt_valid))
        else $error("result raised right after a frame beat");

    // A new result comes only out of a busy period.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rpt_valid) |-> $past(cmd_stall))
        else $error("result raised while the block was idle");

    a_rpt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt_stall |=> rpt_valid && $stable(rpt))
        else $error("stalled result beat dropped or changed");

endmodule

bind airtime_window_rollup awr_checker u_awr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt)
);

@@ tb/airtime_window_rollup_tb.sv @@
module airtime_window_rollup_tb;
    import awr_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int LONG_HOLD    = 3000;
    localparam int PHASE_ITEMS  = 270;
    localparam int DRAIN_CYCLES = 250;

    // Keeps its own copy of the bucket ring and the reports that it still owes.
    class airtime_ledger;
        bit [31:0] slot_epoch[BUCKET_COUNT];
        bit [31:0] slot_rx_ms[BUCKET_COUNT];
        bit [31:0] slot_tx_ms[BUCKET_COUNT];
        rpt_t      expected_reports[$];
        int        errors;

        function new();
            foreach (slot_epoch[i])
            begin
                slot_epoch[i] = '0;
                slot_rx_ms[i] = '0;
                slot_tx_ms[i] = '0;
            end
            errors = 0;
        endfunction

        function bit [15:0] permille_of(bit [63:0] sum_ms);
            bit [63:0] scaled;
            scaled = (sum_ms * 64'(PERMILLE_SCALE)) / 64'(HOUR_MS);
            return (scaled > 64'(FIGURE_MAX)) ? 16'(FIGURE_MAX) : scaled[15:0];
        endfunction

        function void record_cmd(cmd_t c);
            bit [31:0] epoch;
            bit [31:0] age;
            int        slot;
            bit [63:0] rx_sum;
            bit [63:0] tx_sum;
            rpt_t      r;
            epoch = c.time_ms / 32'(BUCKET_LENGTH_MS);
            if (c.operation == OP_FRAME)
            begin
                slot = int'(epoch % 32'(BUCKET_COUNT));
                if (slot_epoch[slot] != epoch)
                begin
                    slot_epoch[slot] = epoch;
                    slot_rx_ms[slot] = '0;
                    slot_tx_ms[slot] = '0;
                end
                if (c.direction == DIR_TX)
                    slot_tx_ms[slot] = slot_tx_ms[slot] + 32'(c.duration_ms);
                else
                    slot_rx_ms[slot] = slot_rx_ms[slot] + 32'(c.duration_ms);
            end
            else
            begin
                rx_sum = '0;
                tx_sum = '0;
                for (int i = 0; i < BUCKET_COUNT; i++)
                begin
                    // A bucket newer than the report wraps to a huge age and drops out.
                    age = epoch - slot_epoch[i];
                    if ((slot_rx_ms[i] != 0 || slot_tx_ms[i] != 0) &&
                        age < 32'(BUCKET_COUNT))
                    begin
                        rx_sum += 64'(slot_rx_ms[i]);
                        tx_sum += 64'(slot_tx_ms[i]);
                    end
                end
                r.rx_permille = permille_of(rx_sum);
                r.tx_permille = permille_of(tx_sum);
                expected_reports.push_back(r);
            end
        endfunction

        function void check_report(rpt_t got);
            rpt_t want;
            if (expected_reports.size() == 0)
            begin
                $error("report beat with nothing expected: rx_permille %0d, tx_permille %0d",
                       got.rx_permille, got.tx_permille);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.rx_permille !== want.rx_permille)
            begin
                $error("rx_permille: expected %0d, actual %0d", want.rx_permille,
                       got.rx_permille);
                errors++;
            end
            if (got.tx_permille !== want.tx_permille)
            begin
                $error("tx_permille: expected %0d, actual %0d", want.tx_permille,
                       got.tx_permille);
                errors++;
            end
        endfunction
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  cmd_valid = 1'b0;
    logic  cmd_stall;
    cmd_t  cmd       = '0;
    logic  rpt_valid;
    logic  rpt_stall = 1'b0;
    rpt_t  rpt;

    airtime_ledger ledger = new();

    int        send_idle_pct  = 0;
    int        stall_pct      = 0;
    int        hold_requests  = 0;
    int        holds_served   = 0;
    int        hold_left      = 0;
    int        cycle_count    = 0;
    bit [31:0] now_ms         = '0;

    airtime_window_rollup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rpt_valid (rpt_valid),
        .rpt_stall (rpt_stall),
        .rpt       (rpt)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Report side: checks each accepted beat and decides the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && rpt_valid && !rpt_stall)
            ledger.check_report(rpt);
        if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left    <= LONG_HOLD;
            rpt_stall    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rpt_stall <= 1'b1;
        end
        else
            rpt_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic cmd_t make_cmd(logic op, logic [31:0] t, logic dir, logic [15:0] dur);
        cmd_t c;
        c.operation   = op;
        c.time_ms     = t;
        c.direction   = dir;
        c.duration_ms = dur;
        return c;
    endfunction

    // Offers one beat and returns in the cycle it is taken; valid stays high for a
    // following beat unless an idle cycle is drawn.
    task automatic send_cmd(input cmd_t c);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            cmd       <= make_cmd(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                                  16'($urandom_range(65535)));
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        ledger.record_cmd(c);
    endtask

    task automatic send_frame(input logic [31:0] t, input logic dir, input logic [15:0] dur);
        send_cmd(make_cmd(OP_FRAME, t, dir, dur));
    endtask

    task automatic send_report(input logic [31:0] t);
        send_cmd(make_cmd(OP_REPORT, t, 1'($urandom_range(1)), 16'($urandom_range(65535))));
    endtask

    task automatic directed_items();
        send_report(32'd0);
        // Epoch zero straight after reset adds to the cleared slot.
        send_frame(32'd0, DIR_RX, 16'hFFFF);
        send_frame(32'd59999, DIR_TX, 16'd0);
        send_frame(32'd59999, DIR_TX, 16'd1234);
        send_report(32'd0);
        send_frame(32'hFFFF_FFFF, DIR_RX, 16'hFFFF);
        // The bucket at the top of the time range lies in the future here.
        send_report(32'd1000);
        send_cmd(make_cmd(OP_REPORT, 32'hFFFF_FFFF, DIR_TX, 16'hFFFF));
        send_cmd(make_cmd(OP_REPORT, 32'hFFFF_FFFF, DIR_RX, 16'h0000));
        // One hour later the same slot is restarted.
        send_frame(32'd3600000, DIR_TX, 16'd100);
        send_report(32'd3600000);
        send_frame(32'd6000000, DIR_TX, 16'hFFFF);
        send_frame(32'd6000000, DIR_RX, 16'h8000);
        send_frame(32'd6059999, DIR_RX, 16'h7FFF);
        // Oldest live age, then one bucket past the window.
        send_report(32'd9540000);
        send_report(32'd9599999);
        send_report(32'd9600000);
        now_ms = 32'd9600000;
    endtask

    task automatic random_items(input int count);
        cmd_t      c;
        int        pick;
        bit [31:0] back_ms;
        bit [15:0] dur;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                c = make_cmd(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                             16'($urandom_range(65535)));
            else
            begin
                if ($urandom_range(99) == 0)
                    now_ms = $urandom;
                else if ($urandom_range(9) == 0)
                    now_ms += $urandom_range(3600000);
                else
                    now_ms += $urandom_range(20000);
                if (pick < 33)
                    c = make_cmd(OP_REPORT, now_ms, 1'($urandom_range(1)),
                                 16'($urandom_range(65535)));
                else
                begin
                    // Mostly inside the hour, a few just past it.
                    back_ms = $urandom_range(3700000);
                    case ($urandom_range(9))
                        0, 1, 2: dur = 16'hFFFF;
                        3:       dur = 16'h0000;
                        default: dur = 16'($urandom_range(65535));
                    endcase
                    c = make_cmd(OP_FRAME, now_ms - back_ms, 1'($urandom_range(1)), dur);
                end
            end
            send_cmd(c);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        random_items(PHASE_ITEMS);

        send_idle_pct = 51;
        random_items(PHASE_ITEMS);

        send_idle_pct = 0;
        stall_pct     = 51;
        random_items(PHASE_ITEMS);

        send_idle_pct = 11;
        stall_pct     = 11;
        random_items(PHASE_ITEMS);

        // The report side holds off for a long stretch while beats keep coming.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests <= hold_requests + 1;
        random_items(PHASE_ITEMS);

        cmd_valid <= 1'b0;
        while (ledger.expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/awr_pkg.sv
rtl/core/awr_div.sv
rtl/core/airtime_window_rollup.sv
rtl/core/awr_checker.sv
tb/airtime_window_rollup_tb.sv
